>>> sv/cleb_pkg.sv
// Package for the cursor line edit buffer.
// Holds the command and response transaction types, command and status codes
// and the default capacity. It depends on nothing else.
package cleb_pkg;

  localparam int CHAR_W           = 8;
  localparam int KIND_W           = 3;
  localparam int STATUS_W         = 2;
  localparam int DEFAULT_CAPACITY = 1024;

  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_in;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_out;
    logic                last_char;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

>>> sv/cleb_stack_ram.sv
// Character store for one stack of the cursor line edit buffer.
// One write port and one registered read port, read-before-write.
// Depends on cleb_pkg for the character width.
module cleb_stack_ram #(
  parameter int DEPTH = cleb_pkg::DEFAULT_CAPACITY
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [cleb_pkg::CHAR_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [cleb_pkg::CHAR_W-1:0]   rd_data
);

  logic [cleb_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/cursor_line_edit_buffer.sv
// Cursor line edit buffer: a line of text with a cursor, kept as two stacks
// (characters before the cursor, and characters after it in reverse order).
// Depends on cleb_pkg and cleb_stack_ram.
//
// One command per clock is sustained while rsp_stall is low; each command
// yields exactly one response via the command register, then the result
// register fed by the registered read port of the stack stores. Stack moves
// write their character in the result stage; a following command that reads
// that location takes it from the result stage. The stores need no clearing
// after reset: only entries below the stack counts are ever read. A read
// command returns the next character of the text from the start, with
// last_char on the final one; any edit command restarts the read-out.
module cursor_line_edit_buffer #(
  parameter int CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  cleb_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cleb_pkg::rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // command register
  logic           s1_valid;
  cleb_pkg::cmd_t s1;

  // counters
  logic [CW-1:0] bc, ac, rp;
  logic [CW-1:0] bc_next, ac_next, rp_next;

  // result stage
  logic                            s2_valid;
  logic [cleb_pkg::STATUS_W-1:0]   s2_status;
  logic                            s2_last;
  logic                            s2_rd;
  logic                            s2_fwd;
  logic [cleb_pkg::CHAR_W-1:0]     s2_fwd_data;
  logic                            s2_from_after;
  logic                            wr_pend;
  logic                            wr_after;
  logic [AW-1:0]                   wr_addr;

  logic [cleb_pkg::CHAR_W-1:0] before_rd, after_rd, cur_value;

  logic                          advance;
  logic [CW-1:0]                 total, pos, pos_back, bc_m1, ac_m1;
  logic [cleb_pkg::STATUS_W-1:0] st;
  logic                          last, rd_ok, rd_after, wr, wr_to_after, ins, fwd;
  logic [AW-1:0]                 rd_addr, wr_addr_c;

  assign advance   = s1_valid && (!s2_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !advance;
  assign cur_value = s2_fwd ? s2_fwd_data : (s2_from_after ? after_rd : before_rd);

  always_comb begin
    total    = bc + ac;
    pos      = (rp >= total) ? '0 : rp;
    pos_back = total - pos - CW'(1);
    bc_m1    = bc - CW'(1);
    ac_m1    = ac - CW'(1);
    bc_next     = bc;
    ac_next     = ac;
    rp_next     = rp;
    st          = cleb_pkg::ST_DONE;
    last        = 1'b0;
    rd_ok       = 1'b0;
    rd_after    = 1'b0;
    rd_addr     = '0;
    wr          = 1'b0;
    wr_to_after = 1'b0;
    wr_addr_c   = '0;
    ins         = 1'b0;
    if (s1.kind <= cleb_pkg::KIND_INSERT) begin
      rp_next = '0;
    end
    case (s1.kind)
      cleb_pkg::KIND_LEFT: begin
        if (bc == '0 || ac >= CAP_C) begin
          st = cleb_pkg::ST_IGNORED;
        end else begin
          bc_next     = bc_m1;
          ac_next     = ac + CW'(1);
          rd_addr     = bc_m1[AW-1:0];
          wr          = 1'b1;
          wr_to_after = 1'b1;
          wr_addr_c   = ac[AW-1:0];
        end
      end
      cleb_pkg::KIND_RIGHT: begin
        if (ac == '0 || bc >= CAP_C) begin
          st = cleb_pkg::ST_IGNORED;
        end else begin
          ac_next   = ac_m1;
          bc_next   = bc + CW'(1);
          rd_after  = 1'b1;
          rd_addr   = ac_m1[AW-1:0];
          wr        = 1'b1;
          wr_addr_c = bc[AW-1:0];
        end
      end
      cleb_pkg::KIND_BACK: begin
        if (bc == '0) begin
          st = cleb_pkg::ST_IGNORED;
        end else begin
          bc_next = bc_m1;
        end
      end
      cleb_pkg::KIND_INSERT: begin
        if (total >= CAP_C || bc >= CAP_C) begin
          st = cleb_pkg::ST_FULL;
        end else begin
          bc_next   = bc + CW'(1);
          wr        = 1'b1;
          wr_addr_c = bc[AW-1:0];
          ins       = 1'b1;
        end
      end
      cleb_pkg::KIND_READ: begin
        if (total == '0) begin
          st = cleb_pkg::ST_EMPTY;
        end else begin
          rd_ok = 1'b1;
          if (pos < bc) begin
            rd_addr = pos[AW-1:0];
          end else begin
            rd_after = 1'b1;
            rd_addr  = pos_back[AW-1:0];
          end
          last    = (pos == total - CW'(1));
          rp_next = last ? '0 : pos + CW'(1);
        end
      end
      default: begin
        st = cleb_pkg::ST_IGNORED;
      end
    endcase
    // location written by the result stage this cycle is not yet in the store
    fwd = ins || (wr_pend && (rd_after == wr_after) && (rd_addr == wr_addr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wr_pend  <= 1'b0;
      bc       <= '0;
      ac       <= '0;
      rp       <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        s2_valid <= 1'b1;
      end else if (s2_valid && !rsp_stall) begin
        s2_valid <= 1'b0;
      end
      wr_pend <= advance && wr;
      if (advance) begin
        bc <= bc_next;
        ac <= ac_next;
        rp <= rp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1 <= cmd;
    end
    if (advance) begin
      s2_status     <= st;
      s2_last       <= last;
      s2_rd         <= rd_ok;
      s2_fwd        <= fwd;
      s2_fwd_data   <= ins ? s1.char_in : cur_value;
      s2_from_after <= rd_after;
      wr_after      <= wr_to_after;
      wr_addr       <= wr_addr_c;
    end
  end

  cleb_stack_ram #(
    .DEPTH(CAPACITY)
  ) u_before (
    .clk     (clk),
    .wr_en   (wr_pend && !wr_after),
    .wr_addr (wr_addr),
    .wr_data (cur_value),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (before_rd)
  );

  cleb_stack_ram #(
    .DEPTH(CAPACITY)
  ) u_after (
    .clk     (clk),
    .wr_en   (wr_pend && wr_after),
    .wr_addr (wr_addr),
    .wr_data (cur_value),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (after_rd)
  );

  assign rsp_valid     = s2_valid;
  assign rsp.char_out  = s2_rd ? cur_value : '0;
  assign rsp.last_char = s2_last;
  assign rsp.status    = s2_status;

endmodule

>>> bench/cursor_line_edit_buffer_tb.sv
// Testbench for cursor_line_edit_buffer: directed command table, then random edit sessions,
// each response checked against a table row or an in-bench model of the two-stack line.
// Depends on cleb_pkg and the cursor_line_edit_buffer RTL.
module cursor_line_edit_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = cleb_pkg::DEFAULT_CAPACITY;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL       = 16;
  localparam int DUE_DEPTH  = 64;

  typedef logic [cleb_pkg::KIND_W-1:0] kind_t;
  typedef logic [cleb_pkg::CHAR_W-1:0] char_t;

  localparam kind_t KIND_SPARE_A = 3'd5;
  localparam kind_t KIND_SPARE_B = 3'd6;
  localparam kind_t KIND_SPARE_C = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  typedef struct packed {
    logic [cleb_pkg::KIND_W-1:0]   kind;
    logic [cleb_pkg::CHAR_W-1:0]   ch;
    logic                          typed;
    logic [cleb_pkg::CHAR_W-1:0]   out;
    logic                          last_mark;
    logic [cleb_pkg::STATUS_W-1:0] st;
  } step_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  cleb_pkg::cmd_t cmd       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  cleb_pkg::rsp_t rsp;

  char_t line_before [CAP];
  char_t line_after  [CAP];
  int n_before = 0;
  int n_after  = 0;
  int read_at  = 0;

  cleb_pkg::rsp_t due [DUE_DEPTH];
  int due_head    = 0;
  int due_tail    = 0;
  int mismatches  = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int hold_reqs   = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int mode_left   = 0;
  stall_mode_t stall_mode = STALL_NONE;

  step_row_t script [0:24] = '{
    '{cleb_pkg::KIND_READ,   8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_EMPTY},
    '{cleb_pkg::KIND_LEFT,   8'hFF, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{cleb_pkg::KIND_RIGHT,  8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{cleb_pkg::KIND_BACK,   8'hFF, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{KIND_SPARE_A,          8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{KIND_SPARE_B,          8'hAA, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{KIND_SPARE_C,          8'hFF, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{cleb_pkg::KIND_INSERT, 8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_INSERT, 8'hFF, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_INSERT, 8'h5A, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'h3C, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'hC3, 1'b1, 8'hFF, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'h00, 1'b1, 8'h5A, 1'b1, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'hFF, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{KIND_SPARE_C,          8'h55, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_IGNORED},
    '{cleb_pkg::KIND_READ,   8'h00, 1'b1, 8'hFF, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_LEFT,   8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'h00, 1'b1, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_LEFT,   8'h81, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_INSERT, 8'hA5, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_READ,   8'h00, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_BACK,   8'h7E, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_RIGHT,  8'h00, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_RIGHT,  8'hFF, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE},
    '{cleb_pkg::KIND_RIGHT,  8'h00, 1'b0, 8'h00, 1'b0, cleb_pkg::ST_DONE}
  };

  cursor_line_edit_buffer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic char_t rand_char();
    return char_t'($urandom_range(0, 255));
  endfunction

  function automatic cleb_pkg::rsp_t apply_edit(cleb_pkg::cmd_t c);
    cleb_pkg::rsp_t r;
    int total;
    r = '0;
    r.status = cleb_pkg::ST_DONE;
    total = n_before + n_after;
    if (c.kind <= cleb_pkg::KIND_INSERT) read_at = 0;
    case (c.kind)
      cleb_pkg::KIND_LEFT: begin
        if (n_before == 0 || n_after >= CAP) begin
          r.status = cleb_pkg::ST_IGNORED;
        end else begin
          n_before--;
          line_after[n_after] = line_before[n_before];
          n_after++;
        end
      end
      cleb_pkg::KIND_RIGHT: begin
        if (n_after == 0 || n_before >= CAP) begin
          r.status = cleb_pkg::ST_IGNORED;
        end else begin
          n_after--;
          line_before[n_before] = line_after[n_after];
          n_before++;
        end
      end
      cleb_pkg::KIND_BACK: begin
        if (n_before == 0) r.status = cleb_pkg::ST_IGNORED;
        else n_before--;
      end
      cleb_pkg::KIND_INSERT: begin
        if (total >= CAP) begin
          r.status = cleb_pkg::ST_FULL;
        end else begin
          line_before[n_before] = c.char_in;
          n_before++;
        end
      end
      cleb_pkg::KIND_READ: begin
        if (total == 0) begin
          r.status = cleb_pkg::ST_EMPTY;
        end else begin
          if (read_at >= total) read_at = 0;
          if (read_at < n_before) r.char_out = line_before[read_at];
          else r.char_out = line_after[n_after - 1 - (read_at - n_before)];
          if (read_at == total - 1) begin
            r.last_char = 1'b1;
            read_at = 0;
          end else begin
            read_at++;
          end
        end
      end
      default: r.status = cleb_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic send_cmd(input kind_t kind, input char_t ch,
                          input logic typed = 1'b0, input cleb_pkg::rsp_t typed_rsp = '0);
    cleb_pkg::rsp_t r;
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd <= cleb_pkg::cmd_t'({kind, ch});
    do @(posedge clk); while (cmd_stall !== 1'b0);
    r = apply_edit(cleb_pkg::cmd_t'({kind, ch}));
    due[due_tail % DUE_DEPTH] = typed ? typed_rsp : r;
    due_tail++;
    if (kind <= cleb_pkg::KIND_READ) items_sent++;
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_tail != due_head);
  endtask

  // one run of related commands: typing, cursor moves, sweeps, read-outs, deletes, noise
  task automatic random_segment();
    int pick;
    int n;
    int total;
    kind_t run_kind;
    kind_t kind;
    bit moves_mix;
    bit any_kind;
    total = n_before + n_after;
    pick = $urandom_range(0, 99);
    moves_mix = 1'b0;
    any_kind = 1'b0;
    run_kind = cleb_pkg::KIND_INSERT;
    n = 1;
    if (pick < 28) begin
      run_kind = (total > 120) ? cleb_pkg::KIND_BACK : cleb_pkg::KIND_INSERT;
      n = $urandom_range(1, 16);
    end else if (pick < 46) begin
      moves_mix = 1'b1;
      n = $urandom_range(1, 20);
    end else if (pick < 54) begin
      if ($urandom_range(0, 1)) begin
        run_kind = cleb_pkg::KIND_LEFT;
        n = n_before;
      end else begin
        run_kind = cleb_pkg::KIND_RIGHT;
        n = n_after;
      end
      n += $urandom_range(1, 2);
      if (n > 100) n = $urandom_range(1, 20);
    end else if (pick < 74) begin
      run_kind = cleb_pkg::KIND_READ;
      n = (total < 60) ? total + $urandom_range(1, 3) : $urandom_range(1, 40);
    end else if (pick < 92) begin
      run_kind = cleb_pkg::KIND_BACK;
      n = $urandom_range(1, 24);
    end else begin
      any_kind = 1'b1;
      n = $urandom_range(1, 6);
    end
    repeat (n) begin
      kind = run_kind;
      if (moves_mix) kind = $urandom_range(0, 1) ? cleb_pkg::KIND_LEFT : cleb_pkg::KIND_RIGHT;
      if (any_kind) kind = kind_t'($urandom_range(cleb_pkg::KIND_LEFT, KIND_SPARE_C));
      send_cmd(kind, rand_char());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = HOLD_LEN;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   rsp_stall <= 1'b0;
        STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 7);
        STALL_TOGGLE: rsp_stall <= ~rsp_stall;
        default:      rsp_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : rsp_check
    cleb_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (due_tail == due_head) begin
        report("response transaction with nothing outstanding");
      end else begin
        want = due[due_head % DUE_DEPTH];
        due_head++;
        if (rsp.char_out !== want.char_out)
          report($sformatf("char_out %h, expected %h", rsp.char_out, want.char_out));
        if (rsp.last_char !== want.last_char)
          report($sformatf("last_char %b, expected %b", rsp.last_char, want.last_char));
        if (rsp.status !== want.status)
          report($sformatf("status %0d, expected %0d", rsp.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 25; i++)
      send_cmd(script[i].kind, script[i].ch, script[i].typed,
               cleb_pkg::rsp_t'({script[i].out, script[i].last_mark, script[i].st}));
    wait_drained();

    while (items_sent < 100) random_segment();
    hold_reqs <= hold_reqs + 1;
    while (items_sent < 200) random_segment();
    wait_drained();

    // fill to capacity, poke at the full line, read the whole text and wrap
    while (n_before + n_after < CAP) send_cmd(cleb_pkg::KIND_INSERT, rand_char());
    repeat (3) send_cmd(cleb_pkg::KIND_INSERT, rand_char());
    send_cmd(cleb_pkg::KIND_LEFT, rand_char());
    send_cmd(cleb_pkg::KIND_INSERT, 8'hFF);
    send_cmd(cleb_pkg::KIND_RIGHT, rand_char());
    send_cmd(cleb_pkg::KIND_BACK, rand_char());
    send_cmd(cleb_pkg::KIND_INSERT, 8'h00);
    send_cmd(cleb_pkg::KIND_INSERT, 8'hFF);
    repeat (CAP + 2) send_cmd(cleb_pkg::KIND_READ, rand_char());

    target = items_sent + 40;
    while (items_sent < target) random_segment();

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
